>>> rtl/core/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 48;
    localparam int MISS_W    = 3;
    localparam int AVG_W     = SAMPLE_W + 8;     // Q.8 average
    localparam int MU_TERM_W = GAIN_W + AVG_W;   // Q.16 mu term, never saturates
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int DEF_MAX_SAMPLES   = 4096;
    localparam int DEF_MAX_INTERVALS = 64;

    // Register reset values
    localparam logic [GAIN_W-1:0] MU_GAIN_RST         = 16'd128;
    localparam logic [GAIN_W-1:0] PEAK_GAIN_RST       = 16'd256;
    localparam logic [GAIN_W-1:0] INTERVAL_WEIGHT_RST = 16'd128;

    localparam logic [MISS_W-1:0]  MISS_LIMIT = 3'd3;
    localparam logic [INDEX_W-1:0] INDEX_MAX  = {INDEX_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MU_GAIN         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_WEIGHT = 2'd2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BOUNDARY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVALUATE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic sample;
        logic boundary;
        logic clear;
    } t_win_cmd;

endpackage

>>> rtl/core/pit_in_if.sv
`timescale 1ns / 1ps

interface pit_in_if;
    import pit_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output action, output sample_value, input ready);
    modport sink   (input valid, input action, input sample_value, output ready);
endinterface

>>> rtl/core/pit_out_if.sv
`timescale 1ns / 1ps

interface pit_out_if;
    import pit_pkg::*;

    logic               valid;
    logic               ready;
    logic               improved;
    logic [INDEX_W-1:0] index_value;
    logic [INDEX_W-1:0] reference_value;
    logic               reference_halved;
    logic [MISS_W-1:0]  misses_now;
    logic               window_empty;

    modport source (output valid, output improved, output index_value,
                    output reference_value, output reference_halved,
                    output misses_now, output window_empty, input ready);
    modport sink   (input valid, input improved, input index_value,
                    input reference_value, input reference_halved,
                    input misses_now, input window_empty, output ready);
endinterface

>>> rtl/core/proximity_index_tracker_unit.sv
`timescale 1ns / 1ps

// Proximity index tracker. Sample items (action 0) and interval boundary items
// (action 1) are taken one per cycle while no evaluation runs and update the
// window sums in place; they give no result. An evaluate item (action 2) closes
// the window and starts an evaluation that holds the input not ready until its
// result is moved to the output register. One shared adder runs a restoring
// divide for the average (DW steps, DW = 24 + clog2(MAX_SAMPLES)), then three
// shift-add multiplies (16, 16 and PW steps, PW = 16 + clog2(MAX_INTERVALS)),
// the final sum and the reference compare.
// The result item waits in an output register, so sample items are taken
// again while it is not yet collected. Configuration writes go straight to
// the gain registers and should only be issued while no evaluation runs.
// Action 3 is taken and dropped.

module proximity_index_tracker_unit #(
    parameter int MAX_SAMPLES   = pit_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_INTERVALS = pit_pkg::DEF_MAX_INTERVALS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pit_in_if.sink                        i_in,
    pit_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [pit_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pit_pkg::GAIN_W-1:0]    i_cfg_data
);
    import pit_pkg::*;

    // Window widths follow from the bounds
    localparam int TW  = 16 + $clog2(MAX_SAMPLES);
    localparam int TLW = $clog2(MAX_SAMPLES + 1);
    localparam int PW  = 16 + $clog2(MAX_INTERVALS);

    logic [GAIN_W-1:0] r_mu_gain;
    logic [GAIN_W-1:0] r_peak_gain;
    logic [GAIN_W-1:0] r_interval_weight;

    logic              accept;
    logic              eval_start;
    t_win_cmd          win_cmd;
    logic [TW-1:0]     win_total;
    logic [TLW-1:0]    win_tally;
    logic [PW-1:0]     win_peak_sum;
    logic              win_empty;

    logic               ev_busy;
    logic               ev_done;
    logic               ev_improved;
    logic [INDEX_W-1:0] ev_index;
    logic [INDEX_W-1:0] ev_reference;
    logic               ev_halved;
    logic [MISS_W-1:0]  ev_misses;
    logic               ev_empty;
    logic               take;

    logic               r_out_valid;
    logic               r_improved;
    logic [INDEX_W-1:0] r_index;
    logic [INDEX_W-1:0] r_reference;
    logic               r_halved;
    logic [MISS_W-1:0]  r_misses;
    logic               r_empty;

    // Configuration registers; writes to an unknown index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_gain         <= MU_GAIN_RST;
            r_peak_gain       <= PEAK_GAIN_RST;
            r_interval_weight <= INTERVAL_WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MU_GAIN:         r_mu_gain         <= i_cfg_data;
                CFG_PEAK_GAIN:       r_peak_gain       <= i_cfg_data;
                CFG_INTERVAL_WEIGHT: r_interval_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input while an evaluation runs
    assign i_in.ready = !ev_busy;
    assign accept     = i_in.valid && i_in.ready;

    // Decode the action of an accepted item
    always_comb begin
        win_cmd    = '0;
        eval_start = 1'b0;
        if (accept) begin
            case (i_in.action)
                ACT_SAMPLE:   win_cmd.sample   = 1'b1;
                ACT_BOUNDARY: win_cmd.boundary = 1'b1;
                ACT_EVALUATE: begin
                    win_cmd.clear = 1'b1;
                    eval_start    = 1'b1;
                end
                ACT_UNUSED:   ;
                default:      ;
            endcase
        end
    end

    pit_window #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .MAX_INTERVALS (MAX_INTERVALS),
        .TW            (TW),
        .TLW           (TLW),
        .PW            (PW)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (win_cmd),
        .i_sample   (i_in.sample_value),
        .o_total    (win_total),
        .o_tally    (win_tally),
        .o_peak_sum (win_peak_sum),
        .o_empty    (win_empty)
    );

    // The evaluator snapshots the window on the same edge that clears it
    pit_eval #(
        .TW  (TW),
        .TLW (TLW),
        .PW  (PW)
    ) u_eval (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (eval_start),
        .i_take            (take),
        .i_total           (win_total),
        .i_tally           (win_tally),
        .i_peak_sum        (win_peak_sum),
        .i_empty           (win_empty),
        .i_mu_gain         (r_mu_gain),
        .i_peak_gain       (r_peak_gain),
        .i_interval_weight (r_interval_weight),
        .o_busy            (ev_busy),
        .o_done            (ev_done),
        .o_improved        (ev_improved),
        .o_index           (ev_index),
        .o_reference       (ev_reference),
        .o_halved          (ev_halved),
        .o_misses          (ev_misses),
        .o_empty           (ev_empty)
    );

    // Move a finished result into the output register once it is free
    assign take = ev_done && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_improved  <= ev_improved;
            r_index     <= ev_index;
            r_reference <= ev_reference;
            r_halved    <= ev_halved;
            r_misses    <= ev_misses;
            r_empty     <= ev_empty;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.improved         = r_improved;
    assign o_out.index_value      = r_index;
    assign o_out.reference_value  = r_reference;
    assign o_out.reference_halved = r_halved;
    assign o_out.misses_now       = r_misses;
    assign o_out.window_empty     = r_empty;
endmodule

>>> rtl/core/pit_alu.sv
`timescale 1ns / 1ps

module pit_alu #(
    parameter int W = 56
) (
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  pit_pkg::t_alu_op i_op,
    output logic [W:0]       o_res
);
    import pit_pkg::*;

    // Top bit: carry on add, borrow on subtract
    always_comb begin
        case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end
endmodule

>>> rtl/core/pit_window.sv
`timescale 1ns / 1ps

module pit_window #(
    parameter int MAX_SAMPLES   = pit_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_INTERVALS = pit_pkg::DEF_MAX_INTERVALS,
    parameter int TW            = 16 + $clog2(MAX_SAMPLES),
    parameter int TLW           = $clog2(MAX_SAMPLES + 1),
    parameter int PW            = 16 + $clog2(MAX_INTERVALS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pit_pkg::t_win_cmd             i_cmd,
    input  logic [pit_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [TW-1:0]                 o_total,
    output logic [TLW-1:0]                o_tally,
    output logic [PW-1:0]                 o_peak_sum,
    output logic                          o_empty
);
    import pit_pkg::*;

    localparam int ICW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    logic [TW-1:0]       r_total,    n_total;
    logic [TLW-1:0]      r_tally,    n_tally;
    logic [SAMPLE_W-1:0] r_peak,     n_peak;
    logic                r_nonempty, n_nonempty;
    logic [PW-1:0]       r_psum,     n_psum;
    logic [ICW-1:0]      r_icount,   n_icount;
    logic [PW-1:0]       closed_sum;
    logic                room_sample;
    logic                room_boundary;

    // Peak sum with the open interval closed
    assign closed_sum    = r_psum + (r_nonempty ? PW'(r_peak) : PW'(0));
    assign room_sample   = ({1'b0, r_tally} < (TLW + 1)'(MAX_SAMPLES));
    assign room_boundary = (({1'b0, r_icount} + (ICW + 1)'(1)) < (ICW + 1)'(MAX_INTERVALS));

    always_comb begin
        n_total    = r_total;
        n_tally    = r_tally;
        n_peak     = r_peak;
        n_nonempty = r_nonempty;
        n_psum     = r_psum;
        n_icount   = r_icount;
        if (i_cmd.clear) begin
            n_total    = '0;
            n_tally    = '0;
            n_peak     = '0;
            n_nonempty = 1'b0;
            n_psum     = '0;
            n_icount   = '0;
        end else if (i_cmd.sample && room_sample) begin
            n_total    = r_total + TW'(i_sample);
            n_tally    = r_tally + TLW'(1);
            n_nonempty = 1'b1;
            if (!r_nonempty || (i_sample > r_peak)) begin
                n_peak = i_sample;
            end
        end else if (i_cmd.boundary && room_boundary) begin
            n_psum     = closed_sum;
            n_peak     = '0;
            n_nonempty = 1'b0;
            n_icount   = r_icount + ICW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_tally    <= '0;
            r_peak     <= '0;
            r_nonempty <= 1'b0;
            r_psum     <= '0;
            r_icount   <= '0;
        end else begin
            r_total    <= n_total;
            r_tally    <= n_tally;
            r_peak     <= n_peak;
            r_nonempty <= n_nonempty;
            r_psum     <= n_psum;
            r_icount   <= n_icount;
        end
    end

    assign o_total    = r_total;
    assign o_tally    = r_tally;
    assign o_peak_sum = closed_sum;
    assign o_empty    = (r_tally == '0);
endmodule

>>> rtl/core/pit_eval.sv
`timescale 1ns / 1ps

module pit_eval #(
    parameter int TW  = 28,
    parameter int TLW = 13,
    parameter int PW  = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_take,
    input  logic [TW-1:0]                i_total,
    input  logic [TLW-1:0]               i_tally,
    input  logic [PW-1:0]                i_peak_sum,
    input  logic                         i_empty,
    input  logic [pit_pkg::GAIN_W-1:0]   i_mu_gain,
    input  logic [pit_pkg::GAIN_W-1:0]   i_peak_gain,
    input  logic [pit_pkg::GAIN_W-1:0]   i_interval_weight,
    output logic                         o_busy,
    output logic                         o_done,
    output logic                         o_improved,
    output logic [pit_pkg::INDEX_W-1:0]  o_index,
    output logic [pit_pkg::INDEX_W-1:0]  o_reference,
    output logic                         o_halved,
    output logic [pit_pkg::MISS_W-1:0]   o_misses,
    output logic                         o_empty
);
    import pit_pkg::*;

    localparam int DW  = TW + 8;                 // dividend {total, 8'b0}
    localparam int AW  = PW + 2 * GAIN_W + 1;    // shared adder width
    localparam int MPW = (PW > GAIN_W) ? PW : GAIN_W;
    localparam int SM1 = (DW > PW) ? DW : PW;
    localparam int SMX = (SM1 > GAIN_W) ? SM1 : GAIN_W;
    localparam int CW  = $clog2(SMX);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_MMU  = 8'b0000_0100,
        S_MPG  = 8'b0000_1000,
        S_MPT  = 8'b0001_0000,
        S_ADD  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state             r_state,    n_state;
    logic [CW-1:0]      r_cnt,      n_cnt;
    logic [INDEX_W-1:0] r_ref,      n_ref;
    logic [MISS_W-1:0]  r_miss,     n_miss;

    logic [TLW-1:0]       r_tally,    n_tally;
    logic [PW-1:0]        r_psum,     n_psum;
    logic                 r_empty,    n_empty;
    logic [DW-1:0]        r_quo,      n_quo;
    logic [TLW-1:0]       r_rem,      n_rem;
    logic [AW-1:0]        r_acc,      n_acc;
    logic [AW-1:0]        r_mcand,    n_mcand;
    logic [MPW-1:0]       r_mplier,   n_mplier;
    logic [MU_TERM_W-1:0] r_mu,       n_mu;
    logic [INDEX_W-1:0]   r_index,    n_index;
    logic                 r_improved, n_improved;
    logic                 r_halved,   n_halved;

    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    t_alu_op       alu_op;
    logic [AW:0]   alu_res;
    logic [TLW:0]  trial;
    logic          borrow;

    pit_alu #(
        .W (AW)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    assign trial  = {r_rem, r_quo[DW-1]};
    assign borrow = alu_res[AW];

    // Operand select for the shared adder
    always_comb begin
        case (r_state)
            S_DIV: begin
                alu_a  = AW'(trial);
                alu_b  = AW'(r_tally);
                alu_op = ALU_SUB;
            end
            S_ADD: begin
                alu_a  = r_acc;
                alu_b  = AW'(r_mu);
                alu_op = ALU_ADD;
            end
            S_CMP: begin
                alu_a  = AW'(r_ref);
                alu_b  = AW'(r_index);
                alu_op = ALU_SUB;
            end
            default: begin
                alu_a  = r_acc;
                alu_b  = r_mcand;
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt + CW'(1);
        n_ref      = r_ref;
        n_miss     = r_miss;
        n_tally    = r_tally;
        n_psum     = r_psum;
        n_empty    = r_empty;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_acc      = r_acc;
        n_mcand    = r_mcand << 1;
        n_mplier   = r_mplier >> 1;
        n_mu       = r_mu;
        n_index    = r_index;
        n_improved = r_improved;
        n_halved   = r_halved;

        // Shift-add step, used by all three multiply phases
        if (r_mplier[0]) begin
            n_acc = alu_res[AW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                n_cnt    = '0;
                n_mcand  = r_mcand;
                n_mplier = r_mplier;
                n_acc    = r_acc;
                if (i_start) begin
                    n_tally = i_tally;
                    n_psum  = i_peak_sum;
                    n_empty = i_empty;
                    n_quo   = {i_total, 8'b0};
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit a step
                n_acc    = r_acc;
                n_mcand  = r_mcand;
                n_mplier = r_mplier;
                n_quo    = {r_quo[DW-2:0], ~borrow};
                n_rem    = borrow ? trial[TLW-1:0] : alu_res[TLW-1:0];
                if (r_cnt == CW'(DW - 1)) begin
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_mcand  = r_empty ? '0 : AW'({r_quo[DW-2:0], ~borrow});
                    n_mplier = MPW'(i_mu_gain);
                    n_state  = S_MMU;
                end
            end
            S_MMU: begin
                if (r_cnt == CW'(GAIN_W - 1)) begin
                    n_cnt    = '0;
                    n_mu     = n_acc[MU_TERM_W-1:0];
                    n_acc    = '0;
                    n_mcand  = AW'(i_peak_gain);
                    n_mplier = MPW'(i_interval_weight);
                    n_state  = S_MPG;
                end
            end
            S_MPG: begin
                if (r_cnt == CW'(GAIN_W - 1)) begin
                    n_cnt    = '0;
                    n_mcand  = n_acc;
                    n_acc    = '0;
                    n_mplier = MPW'(r_psum);
                    n_state  = S_MPT;
                end
            end
            S_MPT: begin
                if (r_cnt == CW'(PW - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                // Sum both terms and saturate to the index width
                n_acc    = r_acc;
                n_mcand  = r_mcand;
                n_mplier = r_mplier;
                if (|alu_res[AW-1:INDEX_W]) begin
                    n_index = INDEX_MAX;
                end else begin
                    n_index = alu_res[INDEX_W-1:0];
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                // Borrow on reference minus index: the index is strictly higher
                n_acc      = r_acc;
                n_mcand    = r_mcand;
                n_mplier   = r_mplier;
                n_improved = borrow;
                n_halved   = 1'b0;
                if (borrow) begin
                    n_ref  = r_index;
                    n_miss = '0;
                end else if (r_miss > MISS_LIMIT) begin
                    n_ref    = r_ref >> 1;
                    n_halved = 1'b1;
                    n_miss   = '0;
                end else begin
                    n_miss = r_miss + MISS_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_acc    = r_acc;
                n_mcand  = r_mcand;
                n_mplier = r_mplier;
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ref   <= '0;
            r_miss  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ref   <= n_ref;
            r_miss  <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tally    <= n_tally;
        r_psum     <= n_psum;
        r_empty    <= n_empty;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_mu       <= n_mu;
        r_index    <= n_index;
        r_improved <= n_improved;
        r_halved   <= n_halved;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_improved  = r_improved;
    assign o_index     = r_index;
    assign o_reference = r_ref;
    assign o_halved    = r_halved;
    assign o_misses    = r_miss;
    assign o_empty     = r_empty;
endmodule
